// ----- rtl/liap_pkg.sv -----
package liap_pkg;
  localparam int unsigned CoordW  = 24;
  localparam int unsigned RadiusW = 23;
  localparam int unsigned SpeedW  = 24;
  localparam int unsigned DiffW   = 25;
  localparam int unsigned SqW     = 50;
  localparam int unsigned SumW    = 52;
  localparam int unsigned DistW   = 26;
  localparam int unsigned TimeW   = 40;
  localparam int unsigned DivNumW = 42;
  localparam int unsigned MulW    = 64;
  localparam int unsigned MulHalf = 32;

  localparam logic [SpeedW-1:0] SpeedReset = 24'd25600;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIST1,
    OP_DIV,
    OP_MOVE,
    OP_DIST2,
    OP_TRAVEL,
    OP_MISS
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic conv;
  } sts_t;
endpackage

// ----- rtl/lead_intercept_aim_point_unit.sv -----
// Lead-intercept aim point. One transaction in, one result out. Each pass runs a
// distance (three summed squares and a 26-step square root), a 42-step division
// for flight time, three split multiplies, a second distance, a travel multiply
// and a miss compare. Passes repeat until the miss is within the hit radius or
// MaxIterations passes have run. The square root and divider are bit-serial and
// shared. shot_speed is sampled when a transaction is accepted; zero is taken as
// one.
module lead_intercept_aim_point_unit #(
  parameter int unsigned MaxIterations = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [liap_pkg::SpeedW-1:0]        cfg_shot_speed_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [liap_pkg::CoordW-1:0] ship_x_i,
  input  logic signed [liap_pkg::CoordW-1:0] ship_y_i,
  input  logic signed [liap_pkg::CoordW-1:0] ship_z_i,
  input  logic signed [liap_pkg::CoordW-1:0] aimed_target_x_i,
  input  logic signed [liap_pkg::CoordW-1:0] aimed_target_y_i,
  input  logic signed [liap_pkg::CoordW-1:0] aimed_target_z_i,
  input  logic signed [liap_pkg::CoordW-1:0] vel_x_i,
  input  logic signed [liap_pkg::CoordW-1:0] vel_y_i,
  input  logic signed [liap_pkg::CoordW-1:0] vel_z_i,
  input  logic [liap_pkg::RadiusW-1:0]       hit_radius_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [liap_pkg::CoordW-1:0] aim_x_o,
  output logic signed [liap_pkg::CoordW-1:0] aim_y_o,
  output logic signed [liap_pkg::CoordW-1:0] aim_z_o,
  output logic                               converged_o
);
  import liap_pkg::*;

  logic [SpeedW-1:0] speed_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) speed_q <= SpeedReset;
    else if (cfg_valid_i) speed_q <= cfg_shot_speed_i;
  end

  liap_ctrl #(.MaxIterations(MaxIterations)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts), .conv_o(converged_o)
  );

  liap_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .speed_i(speed_q),
    .ship_x_i, .ship_y_i, .ship_z_i,
    .tgt_x_i(aimed_target_x_i), .tgt_y_i(aimed_target_y_i), .tgt_z_i(aimed_target_z_i),
    .vel_x_i, .vel_y_i, .vel_z_i, .radius_i(hit_radius_i),
    .aim_x_o, .aim_y_o, .aim_z_o
  );
endmodule

// ----- rtl/liap_ctrl.sv -----
module liap_ctrl #(
  parameter int unsigned MaxIterations = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output liap_pkg::cmd_t   cmd_o,
  input  liap_pkg::sts_t   sts_i,
  output logic             conv_o
);
  import liap_pkg::*;

  localparam int unsigned IterW = $clog2(MaxIterations + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_D1 = 3'd1, S_DIV = 3'd2, S_MOVE = 3'd3,
                         S_D2 = 3'd4, S_TRV = 3'd5, S_MISS = 3'd6, S_OUT = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             conv_q, conv_d;
  logic             issued_q, issued_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign conv_o      = conv_q;

  always_comb begin
    state_d  = state_q;
    iter_d   = iter_q;
    conv_d   = conv_q;
    issued_d = 1'b0;
    cmd_o    = '{start: 1'b0, op: OP_NONE};
    unique case (state_q) inside
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o  = '{start: 1'b1, op: OP_LOAD};
          iter_d = '0;
          state_d = S_D1;
        end
      end
      S_D1, S_DIV, S_MOVE, S_D2, S_TRV, S_MISS: begin
        if (!issued_q) begin
          issued_d = 1'b1;
          unique case (state_q)
            S_D1:   cmd_o = '{start: 1'b1, op: OP_DIST1};
            S_DIV:  cmd_o = '{start: 1'b1, op: OP_DIV};
            S_MOVE: cmd_o = '{start: 1'b1, op: OP_MOVE};
            S_D2:   cmd_o = '{start: 1'b1, op: OP_DIST2};
            S_TRV:  cmd_o = '{start: 1'b1, op: OP_TRAVEL};
            default: cmd_o = '{start: 1'b1, op: OP_MISS};
          endcase
        end else if (sts_i.done) begin
          unique case (state_q)
            S_D1:   state_d = S_DIV;
            S_DIV:  state_d = S_MOVE;
            S_MOVE: state_d = S_D2;
            S_D2:   state_d = S_TRV;
            S_TRV:  state_d = S_MISS;
            default: begin
              iter_d = iter_q + 1'b1;
              conv_d = sts_i.conv;
              if (sts_i.conv || (iter_q + 1'b1) >= IterW'(MaxIterations))
                state_d = S_OUT;
              else
                state_d = S_D1;
            end
          endcase
        end else begin
          issued_d = 1'b1;
        end
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      iter_q   <= '0;
      conv_q   <= 1'b0;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      iter_q   <= iter_d;
      conv_q   <= conv_d;
      issued_q <= issued_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= IterW'(MaxIterations))
    else $error("pass count overrun");
endmodule

// ----- rtl/liap_dp.sv -----
module liap_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  liap_pkg::cmd_t                     cmd_i,
  output liap_pkg::sts_t                     sts_o,
  input  logic [liap_pkg::SpeedW-1:0]        speed_i,
  input  logic signed [liap_pkg::CoordW-1:0] ship_x_i,
  input  logic signed [liap_pkg::CoordW-1:0] ship_y_i,
  input  logic signed [liap_pkg::CoordW-1:0] ship_z_i,
  input  logic signed [liap_pkg::CoordW-1:0] tgt_x_i,
  input  logic signed [liap_pkg::CoordW-1:0] tgt_y_i,
  input  logic signed [liap_pkg::CoordW-1:0] tgt_z_i,
  input  logic signed [liap_pkg::CoordW-1:0] vel_x_i,
  input  logic signed [liap_pkg::CoordW-1:0] vel_y_i,
  input  logic signed [liap_pkg::CoordW-1:0] vel_z_i,
  input  logic [liap_pkg::RadiusW-1:0]       radius_i,
  output logic signed [liap_pkg::CoordW-1:0] aim_x_o,
  output logic signed [liap_pkg::CoordW-1:0] aim_y_o,
  output logic signed [liap_pkg::CoordW-1:0] aim_z_o
);
  import liap_pkg::*;

  logic signed [CoordW-1:0] ship_q [3];
  logic signed [CoordW-1:0] base_q [3];
  logic signed [CoordW-1:0] vel_q  [3];
  logic signed [CoordW-1:0] cur_q  [3];
  logic [RadiusW-1:0] rad_q;
  logic [SpeedW-1:0]  sp_q;
  logic [DistW-1:0]   d1_q, d2_q;
  logic [TimeW-1:0]   t_q;
  logic [TimeW+SpeedW-17:0] trav_q;
  logic               conv_q;

  // shared sequential work: sum of squares, square root, division, multiply
  logic [3:0]         phase_q;
  logic               busy_q;
  logic               done_q;
  op_e                op_q;
  logic [1:0]         ax_q;
  logic [SumW-1:0]    acc_q;
  logic [SumW-1:0]    rem_q;
  logic [DistW-1:0]   root_q;
  logic [5:0]         cnt_q;
  logic [DivNumW-1:0] quo_q;
  logic [SpeedW:0]    drem_q;
  logic [MulW-1:0]    prod_q;
  logic [1:0]         part_q;

  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        mag;
  logic [SqW-1:0]          sq;
  logic [SumW+1:0]         trial;
  logic [SumW+1:0]         remsh;
  logic [SpeedW+1:0]       dsh;
  logic [CoordW-1:0]       vmag;
  logic [MulHalf-1:0]      ma, mb;
  logic [MulW-1:0]         pp;

  always_comb begin
    diff  = DiffW'(ship_q[ax_q]) - DiffW'(cur_q[ax_q]);
    mag   = diff[DiffW-1] ? DiffW'(-diff) : diff;
    sq    = SqW'(mag) * SqW'(mag);
    remsh = {rem_q, acc_q[SumW-1 -: 2]};
    trial = remsh - {root_q, 2'b01};
    dsh   = {drem_q, quo_q[DivNumW-1]};
    vmag  = vel_q[ax_q][CoordW-1] ? CoordW'(-vel_q[ax_q]) : vel_q[ax_q];
    ma    = (op_q == OP_TRAVEL) ? MulHalf'(sp_q) : MulHalf'(vmag);
    mb    = part_q[0] ? MulHalf'(t_q[TimeW-1:MulHalf]) : t_q[MulHalf-1:0];
    pp    = MulW'(ma) * MulW'(mb);
  end

  logic [MulW-1:0] full;
  logic signed [CoordW+1:0] nxt;
  logic [TimeW-1+SpeedW-16:0] shp;
  logic [SumW-1:0] dmiss;

  assign full = prod_q + (pp << MulHalf);
  assign shp  = full[TimeW+SpeedW-1:16];

  // a displacement of 2^24 or more saturates any base point
  always_comb begin
    logic signed [CoordW+1:0] m;
    if (|full[MulW-1:16+CoordW]) m = {2'b01, {CoordW{1'b0}}};
    else m = (CoordW+2)'(full[16+CoordW-1:16]);
    nxt = vel_q[ax_q][CoordW-1] ? (CoordW+2)'(base_q[ax_q]) - m
                                : (CoordW+2)'(base_q[ax_q]) + m;
  end

  assign dmiss = (SumW'(d2_q) > SumW'(trav_q)) ? SumW'(d2_q) - SumW'(trav_q)
                                               : SumW'(trav_q) - SumW'(d2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_NONE;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        op_q    <= cmd_i.op;
        ax_q    <= '0;
        phase_q <= '0;
        part_q  <= '0;
        prod_q  <= '0;
        acc_q   <= '0;
        rem_q   <= '0;
        root_q  <= '0;
        cnt_q   <= '0;
        unique case (cmd_i.op)
          OP_LOAD: begin
            ship_q <= '{ship_x_i, ship_y_i, ship_z_i};
            base_q <= '{tgt_x_i, tgt_y_i, tgt_z_i};
            cur_q  <= '{tgt_x_i, tgt_y_i, tgt_z_i};
            vel_q  <= '{vel_x_i, vel_y_i, vel_z_i};
            rad_q  <= radius_i;
            sp_q   <= (speed_i == '0) ? SpeedW'(1) : speed_i;
          end
          OP_DIV: begin
            quo_q  <= {d1_q, 16'd0};
            drem_q <= '0;
            busy_q <= 1'b1;
          end
          OP_MISS: begin
            conv_q <= (dmiss <= SumW'(rad_q));
            done_q <= 1'b1;
          end
          default: busy_q <= 1'b1;
        endcase
      end else if (busy_q) begin
        unique case (op_q) inside
          OP_DIST1, OP_DIST2: begin
            if (phase_q == 4'd0) begin
              acc_q <= acc_q + SumW'(sq);
              if (ax_q == 2'd2) phase_q <= 4'd1;
              else ax_q <= ax_q + 1'b1;
            end else begin
              if (!trial[SumW+1]) begin
                rem_q  <= trial[SumW-1:0];
                root_q <= {root_q[DistW-2:0], 1'b1};
              end else begin
                rem_q  <= remsh[SumW-1:0];
                root_q <= {root_q[DistW-2:0], 1'b0};
              end
              acc_q <= acc_q << 2;
              cnt_q <= cnt_q + 1'b1;
              if (cnt_q == 6'(DistW-1)) begin
                busy_q <= 1'b0;
                done_q <= 1'b1;
              end
            end
          end
          OP_DIV: begin
            if (dsh >= {1'b0, 1'b0, sp_q}) begin
              drem_q <= (SpeedW+1)'(dsh - {2'b00, sp_q});
              quo_q  <= {quo_q[DivNumW-2:0], 1'b1};
            end else begin
              drem_q <= dsh[SpeedW:0];
              quo_q  <= {quo_q[DivNumW-2:0], 1'b0};
            end
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == 6'(DivNumW-1)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          OP_MOVE: begin
            if (!part_q[0]) begin
              prod_q <= pp;
              part_q <= 2'd1;
            end else begin
              if (nxt > (CoordW+2)'(8388607)) cur_q[ax_q] <= CoordW'(8388607);
              else if (nxt < -(CoordW+2)'(8388608)) cur_q[ax_q] <= {1'b1, {CoordW-1{1'b0}}};
              else cur_q[ax_q] <= CoordW'(nxt);
              part_q <= 2'd0;
              if (ax_q == 2'd2) begin
                busy_q <= 1'b0;
                done_q <= 1'b1;
              end else ax_q <= ax_q + 1'b1;
            end
          end
          OP_TRAVEL: begin
            if (!part_q[0]) begin
              prod_q <= pp;
              part_q <= 2'd1;
            end else begin
              trav_q <= shp;
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          default: busy_q <= 1'b0;
        endcase
      end
      if (busy_q && (op_q == OP_DIST1 || op_q == OP_DIST2) && phase_q != 4'd0 &&
          cnt_q == 6'(DistW-1)) begin
        if (op_q == OP_DIST1) d1_q <= trial[SumW+1] ? {root_q[DistW-2:0], 1'b0}
                                                    : {root_q[DistW-2:0], 1'b1};
        else d2_q <= trial[SumW+1] ? {root_q[DistW-2:0], 1'b0}
                                   : {root_q[DistW-2:0], 1'b1};
      end
      if (busy_q && op_q == OP_DIV && cnt_q == 6'(DivNumW-1)) begin
        logic [DivNumW-1:0] qf;
        qf = {quo_q[DivNumW-2:0], (dsh >= {2'b00, sp_q})};
        t_q <= (|qf[DivNumW-1:TimeW]) ? {TimeW{1'b1}} : qf[TimeW-1:0];
      end
    end
  end

  assign sts_o   = '{done: done_q, conv: conv_q};
  assign aim_x_o = cur_q[0];
  assign aim_y_o = cur_q[1];
  assign aim_z_o = cur_q[2];
endmodule
